/* rtl/expression_token_lexer_assert.svh */
// Assertion helpers used by the checker file.
`ifndef EXPRESSION_TOKEN_LEXER_ASSERT_SVH
`define EXPRESSION_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define ETL_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etl check failed");

// Next-cycle implication, masked while reset is high.
`define ETL_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("etl check failed");

`endif

/* rtl/etl_pkg.sv */
`timescale 1ns / 1ps
package etl_pkg;

  typedef logic [4:0] kind_t;

  localparam kind_t K_IDENT  = 5'd0;
  localparam kind_t K_INT    = 5'd1;
  localparam kind_t K_BOOL   = 5'd2;
  localparam kind_t K_LPAREN = 5'd3;
  localparam kind_t K_RPAREN = 5'd4;
  localparam kind_t K_LBRACE = 5'd5;
  localparam kind_t K_RBRACE = 5'd6;
  localparam kind_t K_COMMA  = 5'd7;
  localparam kind_t K_COLON  = 5'd8;
  localparam kind_t K_ADD    = 5'd9;
  localparam kind_t K_SUB    = 5'd10;
  localparam kind_t K_MUL    = 5'd11;
  localparam kind_t K_DIV    = 5'd12;
  localparam kind_t K_REM    = 5'd13;
  localparam kind_t K_DVT    = 5'd14;
  localparam kind_t K_POS    = 5'd15;
  localparam kind_t K_NEG    = 5'd16;
  localparam kind_t K_SHR    = 5'd17;
  localparam kind_t K_SHL    = 5'd18;
  localparam kind_t K_BIND   = 5'd19;
  localparam kind_t K_RETURN = 5'd20;
  localparam kind_t K_ARROW  = 5'd21;
  localparam kind_t K_END    = 5'd22;
  localparam kind_t K_NONE   = 5'd31;

  localparam logic [3:0] PREC_SHIFT = 4'd10;
  localparam logic [3:0] PREC_ADD   = 4'd11;
  localparam logic [3:0] PREC_MUL   = 4'd12;
  localparam logic [3:0] PREC_UNARY = 4'd13;

  localparam logic [7:0] MAX_TOKEN_LEN = 8'd255;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_PER_BYTE = 3;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [7:0]  length;
    logic        too_long;
    logic        last;
  } token_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["A":"Z"], ["a":"z"]};
  endfunction

  function automatic logic is_op_char(input logic [7:0] c);
    return c inside {"<", ">", "=", "+", "-", "*", "/", "(", ")", "[", "]",
                     ".", ",", "{", "}", ":", "%"};
  endfunction

  function automatic logic is_binary(input kind_t k);
    return k inside {K_ADD, K_SUB, K_MUL, K_DIV, K_REM, K_DVT, K_SHR, K_SHL};
  endfunction

  function automatic logic [3:0] prec_of(input kind_t k);
    logic [3:0] p;
    case (k)
      K_SHR, K_SHL:               p = PREC_SHIFT;
      K_ADD, K_SUB:               p = PREC_ADD;
      K_MUL, K_DIV, K_REM, K_DVT: p = PREC_MUL;
      K_POS, K_NEG:               p = PREC_UNARY;
      default:                    p = 4'd0;
    endcase
    return p;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c, input kind_t prev);
    logic  unary;
    kind_t k;
    unary = (prev == K_NONE) || (prev == K_LPAREN) || (prev == K_LBRACE) ||
            is_binary(prev);
    case (c)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      ":":     k = K_COLON;
      "+":     k = unary ? K_POS : K_ADD;
      "-":     k = unary ? K_NEG : K_SUB;
      "*":     k = K_MUL;
      "/":     k = K_DIV;
      "%":     k = K_REM;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      ",":     k = K_COMMA;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

  function automatic kind_t pair_kind(input logic [7:0] a, input logic [7:0] b);
    kind_t k;
    k = K_NONE;
    if (a == "%" && b == "%") k = K_DVT;
    if (a == ":" && b == "=") k = K_BIND;
    if (a == ":" && b == ":") k = K_RETURN;
    if (a == "-" && b == ">") k = K_ARROW;
    if (a == ">" && b == ">") k = K_SHR;
    if (a == "<" && b == "<") k = K_SHL;
    return k;
  endfunction

endpackage

/* rtl/expression_token_lexer.sv */
// Expression token lexer: one source byte in, up to three tokens out.
// Tokens caused by a byte enter the eight-entry result queue as the byte transfers.
// Throughput: one byte per cycle unless text_stall, which rises when fewer than three
// slots are free; tokens leave one per cycle while token_stall is low.
// Reset (rst, synchronous, active high): scanner back to start of text, queue empty.
`timescale 1ns / 1ps
module expression_token_lexer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  output logic                 token_valid,
  input  logic                 token_stall,
  output etl_pkg::kind_t       token_kind,
  output logic [31:0]          token_start,
  output logic [7:0]           token_length,
  output logic [3:0]           precedence,
  output logic                 right_assoc,
  output logic                 too_long,
  output logic                 last_of_run
);
  import etl_pkg::*;

  // Scanner modes: OP holds one operator byte of lookahead, the LONG modes
  // mark a run whose length has saturated.
  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_OP, M_NUM, M_IDENT, M_NUM_LONG, M_IDENT_LONG
  } mode_t;

  // ---------------------------------------------------------------------
  // Scanner state
  // ---------------------------------------------------------------------
  mode_t       scan_mode,       scan_mode_next;
  logic [7:0]  pending_op_char, pending_op_char_next;
  logic [7:0]  run_length,      run_length_next;
  logic [31:0] run_start,       run_start_next;
  logic [31:0] byte_position,   byte_position_next;
  logic [39:0] leading_chars,   leading_chars_next;
  kind_t       previous_kind,   previous_kind_next;

  // Tokens produced by the byte in transfer, in order.
  token_t      tok [MAX_PER_BYTE];
  logic [1:0]  n_tok;
  token_t      flushed;
  kind_t       pk;
  logic        used;

  // Result queue
  token_t               fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 text_xfer;
  logic                 token_xfer;
  token_t               head;

  // True when the mode holds a token that must go out when the run ends.
  function automatic logic pend_has(input mode_t m);
    return m inside {M_OP, M_NUM, M_NUM_LONG, M_IDENT, M_IDENT_LONG};
  endfunction

  // Token for the pending run or operator. Overlong identifiers never
  // become bool literals.
  function automatic token_t pend_tok(input mode_t m, input logic [7:0] op,
                                      input logic [7:0] len, input logic [31:0] st,
                                      input logic [39:0] lead, input kind_t prev);
    token_t t;
    logic   lf;
    logic   is_bool;
    lf      = (m == M_NUM_LONG) || (m == M_IDENT_LONG);
    is_bool = !lf && ((len == 8'd4 && lead[31:0] == 32'h65757274) ||   // "true"
                      (len == 8'd5 && lead == 40'h65736C6166));        // "false"
    t.start    = st;
    t.last     = 1'b0;
    t.too_long = lf;
    t.length   = len;
    case (m)
      M_OP: begin
        t.kind   = single_kind(op, prev);
        t.length = 8'd1;
      end
      M_NUM, M_NUM_LONG: t.kind = K_INT;
      default:           t.kind = is_bool ? K_BOOL : K_IDENT;
    endcase
    return t;
  endfunction

  assign text_xfer  = text_valid && !text_stall;
  assign token_xfer = token_valid && !token_stall;

  // ---------------------------------------------------------------------
  // Per-byte scan, all in one pass
  // ---------------------------------------------------------------------
  always_comb begin
    scan_mode_next       = scan_mode;
    pending_op_char_next = pending_op_char;
    run_length_next      = run_length;
    run_start_next       = run_start;
    leading_chars_next   = leading_chars;
    previous_kind_next   = previous_kind;
    byte_position_next   = byte_position + 32'd1;
    for (int i = 0; i < MAX_PER_BYTE; i++) tok[i] = '0;
    n_tok   = 2'd0;
    used    = 1'b0;
    flushed = '0;
    pk      = pair_kind(pending_op_char, text_byte);

    // Stage one: continue or close whatever is open.
    case (scan_mode)
      M_OP: begin
        if (pk != K_NONE) begin
          tok[n_tok] = '{kind: pk, start: run_start, length: 8'd2,
                         too_long: 1'b0, last: 1'b0};
          n_tok = n_tok + 2'd1;
          previous_kind_next = pk;
          scan_mode_next = M_IDLE;
          used = 1'b1;
        end
      end
      M_NUM, M_NUM_LONG: used = is_digit(text_byte);
      M_IDENT, M_IDENT_LONG: used = is_digit(text_byte) || is_alpha(text_byte);
      M_COMMENT: begin
        if (text_byte == 8'd10) scan_mode_next = M_IDLE;
        used = 1'b1;
      end
      default: ;
    endcase

    if ((scan_mode != M_OP) && (scan_mode != M_COMMENT) && (scan_mode != M_IDLE)) begin
      if (used) begin
        // extend the run; only the first five characters are kept
        for (int i = 0; i < 5; i++) begin
          if (run_length == 8'(i))
            leading_chars_next[8*i +: 8] = leading_chars[8*i +: 8] | text_byte;
        end
        if (run_length < MAX_TOKEN_LEN) run_length_next = run_length + 8'd1;
        else if (scan_mode == M_NUM) scan_mode_next = M_NUM_LONG;
        else if (scan_mode == M_IDENT) scan_mode_next = M_IDENT_LONG;
      end
    end

    if ((scan_mode == M_OP && pk == K_NONE) ||
        ((scan_mode != M_OP) && pend_has(scan_mode) && !used)) begin
      flushed = pend_tok(scan_mode, pending_op_char, run_length, run_start,
                         leading_chars, previous_kind_next);
      tok[n_tok] = flushed;
      n_tok = n_tok + 2'd1;
      previous_kind_next = flushed.kind;
      scan_mode_next = M_IDLE;
    end

    // Stage two: a byte not taken by stage one may open something new.
    if (!used && scan_mode_next == M_IDLE) begin
      if (is_space(text_byte)) begin
      end else if (text_byte == "#") begin
        scan_mode_next = M_COMMENT;
      end else if (is_op_char(text_byte)) begin
        scan_mode_next       = M_OP;
        pending_op_char_next = text_byte;
        run_start_next       = byte_position;
        run_length_next      = 8'd1;
      end else if (is_digit(text_byte) || is_alpha(text_byte)) begin
        scan_mode_next     = is_digit(text_byte) ? M_NUM : M_IDENT;
        run_start_next     = byte_position;
        run_length_next    = 8'd1;
        leading_chars_next = {32'd0, text_byte};
      end
    end

    // End of text: flush, end marker, back to reset state.
    if (end_of_text) begin
      if (pend_has(scan_mode_next)) begin
        flushed = pend_tok(scan_mode_next, pending_op_char_next, run_length_next,
                           run_start_next, leading_chars_next, previous_kind_next);
        tok[n_tok] = flushed;
        n_tok = n_tok + 2'd1;
      end
      tok[n_tok] = '{kind: K_END, start: byte_position_next, length: 8'd0,
                     too_long: 1'b0, last: 1'b0};
      n_tok = n_tok + 2'd1;
      scan_mode_next       = M_IDLE;
      pending_op_char_next = 8'd0;
      run_length_next      = 8'd0;
      run_start_next       = 32'd0;
      byte_position_next   = 32'd0;
      leading_chars_next   = 40'd0;
      previous_kind_next   = K_NONE;
    end

    if (n_tok != 2'd0) tok[n_tok - 2'd1].last = 1'b1;
  end

  // ---------------------------------------------------------------------
  // State and result queue
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode       <= M_IDLE;
      pending_op_char <= 8'd0;
      run_length      <= 8'd0;
      run_start       <= 32'd0;
      byte_position   <= 32'd0;
      leading_chars   <= 40'd0;
      previous_kind   <= K_NONE;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      count           <= '0;
    end else begin
      if (text_xfer) begin
        scan_mode       <= scan_mode_next;
        pending_op_char <= pending_op_char_next;
        run_length      <= run_length_next;
        run_start       <= run_start_next;
        byte_position   <= byte_position_next;
        leading_chars   <= leading_chars_next;
        previous_kind   <= previous_kind_next;
        for (int i = 0; i < MAX_PER_BYTE; i++) begin
          if (2'(i) < n_tok) fifo[wr_ptr + FIFO_AW'(i)] <= tok[i];
        end
        wr_ptr <= wr_ptr + FIFO_AW'(n_tok);
      end
      if (token_xfer) rd_ptr <= rd_ptr + FIFO_AW'(1);
      count <= count + (text_xfer ? CNT_W'(n_tok) : CNT_W'(0))
                     - (token_xfer ? CNT_W'(1) : CNT_W'(0));
    end
  end

  // registered count only, so stall never depends on this cycle's valid
  assign text_stall = count > CNT_W'(FIFO_DEPTH - MAX_PER_BYTE);

  assign head         = fifo[rd_ptr];
  assign token_valid  = count != '0;
  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign too_long     = head.too_long;
  assign last_of_run  = head.last;
  assign precedence   = prec_of(head.kind);
  assign right_assoc  = (head.kind == K_POS) || (head.kind == K_NEG);

endmodule

/* rtl/etl_checker.sv */
`timescale 1ns / 1ps
`include "expression_token_lexer_assert.svh"
module etl_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 token_valid,
  input logic                 token_stall,
  input etl_pkg::kind_t       token_kind,
  input logic [31:0]          token_start,
  input logic [7:0]           token_length,
  input logic [3:0]           precedence,
  input logic                 right_assoc,
  input logic                 too_long,
  input logic                 last_of_run
);
  import etl_pkg::*;

  logic [51:0] tok_word;
  logic        held;
  logic        end_seen;

  assign tok_word = {token_kind, token_start, token_length, precedence, right_assoc,
                     too_long, last_of_run};
  assign held     = token_valid && token_stall;
  assign end_seen = token_valid && (token_kind == K_END);

  // queue is empty straight after reset
  `ETL_ASSERT_IMP(a_empty_after_rst, clk, rst, $past(rst), !token_valid)

  // a held token stays put
  `ETL_ASSERT_NXT(a_token_hold, clk, rst, held, token_valid && $stable(tok_word))

  // end marker closes its byte's run and carries no characters
  `ETL_ASSERT_IMP(a_end_marker, clk, rst, end_seen, last_of_run && token_length == '0 && !too_long)

  // only unary signs bind right, and they alone have top precedence
  `ETL_ASSERT_IMP(a_unary_prec, clk, rst, token_valid, right_assoc == (precedence == PREC_UNARY))

endmodule

bind expression_token_lexer etl_checker u_etl_checker (.*);
